### design/b64enc_pkg.sv
// Package: shared types, constants and the base64 character map for the stream encoder.
`timescale 1ns / 1ps

package b64enc_pkg;

  // Default depth of the queue between front and back
  localparam int unsigned QUEUE_DEPTH = 2;

  // Pad character '='
  localparam logic [6:0] PAD_CHAR = 7'd61;

  // Bytes held in the current group
  typedef enum logic [1:0] {
    POS_EMPTY = 2'd0,
    POS_ONE   = 2'd1,
    POS_TWO   = 2'd2,
    POS_SPARE = 2'd3
  } group_pos_e;

  // Input beat
  typedef struct packed {
    logic [7:0] data_byte;
    logic       final_byte;
  } in_beat_t;

  // Output beat: one quad of characters
  typedef struct packed {
    logic [6:0] first_char;
    logic [6:0] second_char;
    logic [6:0] third_char;
    logic [6:0] fourth_char;
    logic       stream_end;
  } out_beat_t;

  // Completed group handed from front to back
  typedef struct packed {
    logic [23:0] triple;
    logic [1:0]  count;
    logic        last;
  } group_t;

  // Six-bit value to standard-alphabet ASCII
  function automatic logic [6:0] b64_char(input logic [5:0] six);
    logic [6:0] v;
    v = {1'b0, six};
    if (six < 6'd26) begin
      b64_char = v + 7'd65;
    end else if (six < 6'd52) begin
      b64_char = v + 7'd71;
    end else if (six < 6'd62) begin
      b64_char = v - 7'd4;
    end else if (six == 6'd62) begin
      b64_char = 7'd43;
    end else begin
      b64_char = 7'd47;
    end
  endfunction

endpackage

### design/base64_stream_encoder.sv
// Top level: streaming base64 encoder, front end, group queue and back end.
`timescale 1ns / 1ps

// Takes one byte per beat and returns one quad of four base64 characters for each
// group of three bytes, or for a short group ended by final_byte, padded with '='.
// Sustained rate is one byte per cycle while in_stall_o is low; a quad passes
// from the beat that completes its group through a queue entry, written at the
// accepting edge, to the output register in the back, loaded when the back takes it.
// The group queue of QDepth entries lets the byte side keep running for that many
// quads while the output side is stalled; in_stall_o rises only when it is full.
// After a final byte the next beat starts a new stream.
module base64_stream_encoder #(
  parameter int unsigned QDepth = b64enc_pkg::QUEUE_DEPTH
) (
  input  logic                  clk_i,
  input  logic                  rst_ni,
  input  logic                  in_valid_i,
  input  b64enc_pkg::in_beat_t  in_beat_i,
  output logic                  in_stall_o,
  output logic                  out_valid_o,
  output b64enc_pkg::out_beat_t out_beat_o,
  input  logic                  out_stall_i
);

  logic               q_full, q_push, q_pop, q_valid;
  b64enc_pkg::group_t push_group, pop_group;

  b64enc_front u_front (
    .clk_i        (clk_i),
    .rst_ni       (rst_ni),
    .in_valid_i   (in_valid_i),
    .in_beat_i    (in_beat_i),
    .in_stall_o   (in_stall_o),
    .q_full_i     (q_full),
    .push_o       (q_push),
    .push_group_o (push_group)
  );

  b64enc_fifo #(
    .Depth (QDepth)
  ) u_fifo (
    .clk_i        (clk_i),
    .rst_ni       (rst_ni),
    .push_i       (q_push),
    .push_group_i (push_group),
    .full_o       (q_full),
    .pop_i        (q_pop),
    .valid_o      (q_valid),
    .pop_group_o  (pop_group)
  );

  b64enc_back u_back (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .q_valid_i   (q_valid),
    .q_group_i   (pop_group),
    .pop_o       (q_pop),
    .out_valid_o (out_valid_o),
    .out_beat_o  (out_beat_o),
    .out_stall_i (out_stall_i)
  );

endmodule

### design/b64enc_front.sv
// Front end: accepts byte beats and assembles groups of up to three bytes.
`timescale 1ns / 1ps

module b64enc_front (
  input  logic                clk_i,
  input  logic                rst_ni,
  input  logic                in_valid_i,
  input  b64enc_pkg::in_beat_t in_beat_i,
  output logic                in_stall_o,
  input  logic                q_full_i,
  output logic                push_o,
  output b64enc_pkg::group_t  push_group_o
);

  b64enc_pkg::group_pos_e pos_q, pos_d;
  logic [15:0]            held_q, held_d;
  logic                   accept;
  logic [15:0]            merged;

  assign in_stall_o = q_full_i;
  assign accept     = in_valid_i && !q_full_i;
  assign merged     = {held_q[15:8], in_beat_i.data_byte};

  // Group assembly
  always_comb begin
    pos_d        = pos_q;
    held_d       = held_q;
    push_o       = 1'b0;
    push_group_o = '0;
    if (accept) begin
      case (pos_q)
        b64enc_pkg::POS_ONE: begin
          if (in_beat_i.final_byte) begin
            push_o       = 1'b1;
            push_group_o = '{triple: {merged, 8'h00}, count: 2'd2, last: 1'b1};
            pos_d        = b64enc_pkg::POS_EMPTY;
            held_d       = '0;
          end else begin
            pos_d  = b64enc_pkg::POS_TWO;
            held_d = merged;
          end
        end
        b64enc_pkg::POS_TWO: begin
          push_o       = 1'b1;
          push_group_o = '{triple: {held_q, in_beat_i.data_byte}, count: 2'd3,
                           last: in_beat_i.final_byte};
          pos_d        = b64enc_pkg::POS_EMPTY;
          held_d       = '0;
        end
        default: begin
          // empty group (the spare code behaves the same)
          if (in_beat_i.final_byte) begin
            push_o       = 1'b1;
            push_group_o = '{triple: {in_beat_i.data_byte, 16'h0000}, count: 2'd1,
                             last: 1'b1};
            pos_d        = b64enc_pkg::POS_EMPTY;
            held_d       = '0;
          end else begin
            pos_d  = b64enc_pkg::POS_ONE;
            held_d = {in_beat_i.data_byte, 8'h00};
          end
        end
      endcase
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      pos_q  <= b64enc_pkg::POS_EMPTY;
      held_q <= '0;
    end else begin
      pos_q  <= pos_d;
      held_q <= held_d;
    end
  end

  // Spare position is never entered
  a_pos_legal: assert property (@(posedge clk_i) disable iff (!rst_ni)
    pos_q != b64enc_pkg::POS_SPARE)
    else $error("front: group position reached spare code");

  // A group is pushed only for an accepted beat
  a_push_on_accept: assert property (@(posedge clk_i) disable iff (!rst_ni)
    push_o |-> (in_valid_i && !in_stall_o))
    else $error("front: push without an accepted beat");

endmodule

### design/b64enc_fifo.sv
// Queue: small FIFO of completed groups between front and back.
`timescale 1ns / 1ps

module b64enc_fifo #(
  parameter int unsigned Depth = b64enc_pkg::QUEUE_DEPTH
) (
  input  logic               clk_i,
  input  logic               rst_ni,
  input  logic               push_i,
  input  b64enc_pkg::group_t push_group_i,
  output logic               full_o,
  input  logic               pop_i,
  output logic               valid_o,
  output b64enc_pkg::group_t pop_group_o
);

  localparam int unsigned PtrW = (Depth > 1) ? $clog2(Depth) : 1;
  localparam int unsigned CntW = $clog2(Depth + 1);

  b64enc_pkg::group_t mem_q [Depth];
  logic [PtrW-1:0]    wr_ptr_q, wr_ptr_d;
  logic [PtrW-1:0]    rd_ptr_q, rd_ptr_d;
  logic [CntW-1:0]    cnt_q, cnt_d;
  logic               do_push, do_pop;

  assign full_o      = (cnt_q == CntW'(Depth));
  assign valid_o     = (cnt_q != '0);
  assign pop_group_o = mem_q[rd_ptr_q];
  assign do_push     = push_i && !full_o;
  assign do_pop      = pop_i && valid_o;

  // Pointer and count update
  always_comb begin
    wr_ptr_d = wr_ptr_q;
    rd_ptr_d = rd_ptr_q;
    cnt_d    = cnt_q;
    if (do_push) begin
      wr_ptr_d = (wr_ptr_q == PtrW'(Depth - 1)) ? '0 : wr_ptr_q + 1'b1;
    end
    if (do_pop) begin
      rd_ptr_d = (rd_ptr_q == PtrW'(Depth - 1)) ? '0 : rd_ptr_q + 1'b1;
    end
    if (do_push && !do_pop) begin
      cnt_d = cnt_q + 1'b1;
    end else if (do_pop && !do_push) begin
      cnt_d = cnt_q - 1'b1;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      wr_ptr_q <= '0;
      rd_ptr_q <= '0;
      cnt_q    <= '0;
    end else begin
      wr_ptr_q <= wr_ptr_d;
      rd_ptr_q <= rd_ptr_d;
      cnt_q    <= cnt_d;
    end
  end

  // Storage, no reset needed
  always_ff @(posedge clk_i) begin
    if (do_push) begin
      mem_q[wr_ptr_q] <= push_group_i;
    end
  end

  a_no_overflow: assert property (@(posedge clk_i) disable iff (!rst_ni)
    !(push_i && full_o))
    else $error("fifo: push while full");

  a_cnt_bound: assert property (@(posedge clk_i) disable iff (!rst_ni)
    cnt_q <= CntW'(Depth))
    else $error("fifo: count above depth");

endmodule

### design/b64enc_back.sv
// Back end: maps a group to four base64 characters and holds the output beat.
`timescale 1ns / 1ps

module b64enc_back (
  input  logic                  clk_i,
  input  logic                  rst_ni,
  input  logic                  q_valid_i,
  input  b64enc_pkg::group_t    q_group_i,
  output logic                  pop_o,
  output logic                  out_valid_o,
  output b64enc_pkg::out_beat_t out_beat_o,
  input  logic                  out_stall_i
);

  logic                  out_valid_q, out_valid_d;
  b64enc_pkg::out_beat_t out_beat_q, quad;

  assign pop_o = q_valid_i && (!out_valid_q || !out_stall_i);

  // Character mapping and padding
  always_comb begin
    quad.first_char  = b64enc_pkg::b64_char(q_group_i.triple[23:18]);
    quad.second_char = b64enc_pkg::b64_char(q_group_i.triple[17:12]);
    quad.third_char  = (q_group_i.count >= 2'd2) ?
                       b64enc_pkg::b64_char(q_group_i.triple[11:6]) : b64enc_pkg::PAD_CHAR;
    quad.fourth_char = (q_group_i.count == 2'd3) ?
                       b64enc_pkg::b64_char(q_group_i.triple[5:0]) : b64enc_pkg::PAD_CHAR;
    quad.stream_end  = q_group_i.last;
  end

  // Output register valid
  always_comb begin
    out_valid_d = out_valid_q;
    if (pop_o) begin
      out_valid_d = 1'b1;
    end else if (!out_stall_i) begin
      out_valid_d = 1'b0;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_valid_q <= 1'b0;
    end else begin
      out_valid_q <= out_valid_d;
    end
  end

  always_ff @(posedge clk_i) begin
    if (pop_o) begin
      out_beat_q <= quad;
    end
  end

  assign out_valid_o = out_valid_q;
  assign out_beat_o  = out_beat_q;

endmodule

### tb/tb_top.sv
// Self-checking testbench for the base64 stream encoder: directed table, then random streams.
`timescale 1ns / 1ps

module tb_top;

  // Cycles with no accepted beat on either side before the run is declared hung
  localparam int unsigned HANG_LIMIT = 2000;
  // Cycles to wait after the last quad arrives, covering the queue and the output register
  localparam int unsigned DRAIN_CYCLES = 8;
  // Random byte budget per idling phase
  localparam int unsigned PHASE_BYTES = 400;

  // Standard alphabet, index 0 in the top byte
  localparam logic [0:63][7:0] B64_MAP =
      "ABCDEFGHIJKLMNOPQRSTUVWXYZabcdefghijklmnopqrstuvwxyz0123456789+/";

  // One row of the directed table; chars is only used when typed is set
  typedef struct packed {
    logic [7:0]  data;
    logic        fin;
    logic        typed;
    logic [31:0] chars;
    logic        end_flag;
  } dir_row_t;

  localparam int unsigned NUM_ROWS = 24;
  localparam dir_row_t DIR_ROWS [NUM_ROWS] = '{
    // lone byte at stream start, both extremes
    '{8'h00, 1'b1, 1'b1, "AA==", 1'b1},
    '{8'hFF, 1'b1, 1'b1, "/w==", 1'b1},
    // two-byte final group
    '{8'hFF, 1'b0, 1'b0, "    ", 1'b0},
    '{8'hFF, 1'b1, 1'b1, "//8=", 1'b1},
    // full groups, not final and final
    '{8'hFF, 1'b0, 1'b0, "    ", 1'b0},
    '{8'hFF, 1'b0, 1'b0, "    ", 1'b0},
    '{8'hFF, 1'b0, 1'b1, "////", 1'b0},
    '{8'h00, 1'b0, 1'b0, "    ", 1'b0},
    '{8'h00, 1'b0, 1'b0, "    ", 1'b0},
    '{8'h00, 1'b1, 1'b1, "AAAA", 1'b1},
    // "Man", "Ma", "M"
    '{8'h4D, 1'b0, 1'b0, "    ", 1'b0},
    '{8'h61, 1'b0, 1'b0, "    ", 1'b0},
    '{8'h6E, 1'b0, 1'b1, "TWFu", 1'b0},
    '{8'h4D, 1'b0, 1'b0, "    ", 1'b0},
    '{8'h61, 1'b1, 1'b1, "TWE=", 1'b1},
    '{8'h4D, 1'b1, 1'b1, "TQ==", 1'b1},
    // every sextet 62
    '{8'hFB, 1'b0, 1'b0, "    ", 1'b0},
    '{8'hEF, 1'b0, 1'b0, "    ", 1'b0},
    '{8'hBE, 1'b1, 1'b1, "++++", 1'b1},
    // mixed bytes, checked by the predictor
    '{8'h12, 1'b0, 1'b0, "    ", 1'b0},
    '{8'h34, 1'b0, 1'b0, "    ", 1'b0},
    '{8'h56, 1'b0, 1'b0, "    ", 1'b0},
    '{8'h78, 1'b0, 1'b0, "    ", 1'b0},
    '{8'h9A, 1'b1, 1'b0, "    ", 1'b0}
  };

  logic                  clk_i = 1'b0;
  logic                  rst_ni = 1'b0;
  logic                  in_valid_i = 1'b0;
  b64enc_pkg::in_beat_t  in_beat_i = '0;
  logic                  in_stall_o;
  logic                  out_valid_o;
  b64enc_pkg::out_beat_t out_beat_o;
  logic                  out_stall_i = 1'b0;

  // Idling percentages of the current phase
  int unsigned in_idle_pct = 0;
  int unsigned out_stall_pct = 0;

  // Predictor state
  b64enc_pkg::group_pos_e enc_pos = b64enc_pkg::POS_EMPTY;
  logic [15:0]            enc_held = '0;

  b64enc_pkg::out_beat_t quad_q[$];
  int unsigned           mismatch_cnt = 0;
  int unsigned           hang_cnt = 0;

  base64_stream_encoder i_dut (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .in_valid_i  (in_valid_i),
    .in_beat_i   (in_beat_i),
    .in_stall_o  (in_stall_o),
    .out_valid_o (out_valid_o),
    .out_beat_o  (out_beat_o),
    .out_stall_i (out_stall_i)
  );

  initial begin
    forever #5 clk_i = ~clk_i;
  end

  function automatic logic [6:0] b64_of(input logic [5:0] six);
    return B64_MAP[six][6:0];
  endfunction

  // Advance the group state by one byte; returns 1 with the quad when one is due
  function automatic bit encode_byte(input b64enc_pkg::in_beat_t b,
                                     output b64enc_pkg::out_beat_t q);
    logic [23:0]            grp;
    logic [1:0]             n;
    b64enc_pkg::group_pos_e p;
    p = (enc_pos == b64enc_pkg::POS_SPARE) ? b64enc_pkg::POS_EMPTY : enc_pos;
    q = '0;
    case (p)
      b64enc_pkg::POS_EMPTY: begin
        grp = {b.data_byte, 16'h0000};
        n = 2'd1;
      end
      b64enc_pkg::POS_ONE: begin
        grp = {enc_held[15:8], b.data_byte, 8'h00};
        n = 2'd2;
      end
      default: begin
        grp = {enc_held, b.data_byte};
        n = 2'd3;
      end
    endcase
    // short group still open: just hold the byte
    if (n != 2'd3 && !b.final_byte) begin
      enc_held = (p == b64enc_pkg::POS_EMPTY) ? {b.data_byte, 8'h00} :
                                                {enc_held[15:8], b.data_byte};
      enc_pos = (p == b64enc_pkg::POS_EMPTY) ? b64enc_pkg::POS_ONE : b64enc_pkg::POS_TWO;
      return 1'b0;
    end
    q.first_char  = b64_of(grp[23:18]);
    q.second_char = b64_of(grp[17:12]);
    q.third_char  = (n >= 2'd2) ? b64_of(grp[11:6]) : b64enc_pkg::PAD_CHAR;
    q.fourth_char = (n == 2'd3) ? b64_of(grp[5:0]) : b64enc_pkg::PAD_CHAR;
    q.stream_end  = b.final_byte;
    enc_pos = b64enc_pkg::POS_EMPTY;
    enc_held = '0;
    return 1'b1;
  endfunction

  // Offer one byte beat, wait for it to be taken, then queue its quad if any
  task automatic send_byte(input b64enc_pkg::in_beat_t b, input bit typed,
                           input b64enc_pkg::out_beat_t typed_quad);
    b64enc_pkg::out_beat_t q;
    bit                    has_q;
    while ($urandom_range(99) < in_idle_pct) begin
      in_valid_i <= 1'b0;
      @(posedge clk_i);
    end
    in_valid_i <= 1'b1;
    in_beat_i  <= b;
    @(posedge clk_i);
    while (in_stall_o) @(posedge clk_i);
    has_q = encode_byte(b, q);
    if (has_q) quad_q.push_back(typed ? typed_quad : q);
  endtask

  // Random stream: mostly short, some long, ends on a final byte
  task automatic send_stream(output int unsigned n_bytes);
    int unsigned          len;
    b64enc_pkg::in_beat_t b;
    len = ($urandom_range(99) < 80) ? $urandom_range(1, 9) : $urandom_range(10, 40);
    for (int unsigned k = 0; k < len; k++) begin
      case ($urandom_range(9))
        0:       b.data_byte = 8'h00;
        1:       b.data_byte = 8'hFF;
        default: b.data_byte = 8'($urandom_range(255));
      endcase
      b.final_byte = (k == len - 1);
      send_byte(b, 1'b0, '0);
    end
    n_bytes = len;
  endtask

  // Receiver stall
  always @(posedge clk_i) begin
    out_stall_i <= ($urandom_range(99) < out_stall_pct);
  end

  // Quad checker
  always @(posedge clk_i) begin
    if (rst_ni && out_valid_o && !out_stall_i) begin
      b64enc_pkg::out_beat_t want;
      if (quad_q.size() == 0) begin
        $display("%0t: unexpected quad %c%c%c%c end=%0d", $time,
                 out_beat_o.first_char, out_beat_o.second_char,
                 out_beat_o.third_char, out_beat_o.fourth_char, out_beat_o.stream_end);
        mismatch_cnt++;
      end else begin
        want = quad_q.pop_front();
        if (out_beat_o.first_char !== want.first_char ||
            out_beat_o.second_char !== want.second_char ||
            out_beat_o.third_char !== want.third_char ||
            out_beat_o.fourth_char !== want.fourth_char ||
            out_beat_o.stream_end !== want.stream_end) begin
          $display("%0t: quad mismatch exp %c%c%c%c end=%0d got %c%c%c%c end=%0d", $time,
                   want.first_char, want.second_char, want.third_char,
                   want.fourth_char, want.stream_end,
                   out_beat_o.first_char, out_beat_o.second_char,
                   out_beat_o.third_char, out_beat_o.fourth_char, out_beat_o.stream_end);
          mismatch_cnt++;
        end
      end
    end
  end

  // Hang watchdog: cycles with no beat taken on either side
  always @(posedge clk_i) begin
    if (!rst_ni || (in_valid_i && !in_stall_o) || (out_valid_o && !out_stall_i)) begin
      hang_cnt <= 0;
    end else if (hang_cnt >= HANG_LIMIT) begin
      $display("== FAIL ==");
      $finish;
    end else begin
      hang_cnt <= hang_cnt + 1;
    end
  end

  // Main sequence
  initial begin
    b64enc_pkg::in_beat_t  b;
    b64enc_pkg::out_beat_t tq;
    int unsigned           sent;
    int unsigned           n;

    repeat (4) @(posedge clk_i);
    rst_ni <= 1'b1;
    @(posedge clk_i);

    // Directed table, no idling
    for (int unsigned r = 0; r < NUM_ROWS; r++) begin
      b.data_byte    = DIR_ROWS[r].data;
      b.final_byte   = DIR_ROWS[r].fin;
      tq.first_char  = DIR_ROWS[r].chars[30:24];
      tq.second_char = DIR_ROWS[r].chars[22:16];
      tq.third_char  = DIR_ROWS[r].chars[14:8];
      tq.fourth_char = DIR_ROWS[r].chars[6:0];
      tq.stream_end  = DIR_ROWS[r].end_flag;
      send_byte(b, DIR_ROWS[r].typed, tq);
    end

    // Random streams over the idling phases: none, sender, receiver, both
    for (int ph = 0; ph < 4; ph++) begin
      case (ph)
        0: begin in_idle_pct = 0;  out_stall_pct = 0;  end
        1: begin in_idle_pct = 65; out_stall_pct = 0;  end
        2: begin in_idle_pct = 0;  out_stall_pct = 65; end
        default: begin in_idle_pct = 24; out_stall_pct = 24; end
      endcase
      sent = 0;
      while (sent < PHASE_BYTES) begin
        send_stream(n);
        sent += n;
      end
    end

    in_valid_i <= 1'b0;
    while (quad_q.size() != 0) @(posedge clk_i);
    repeat (DRAIN_CYCLES) @(posedge clk_i);

    if (mismatch_cnt == 0 && quad_q.size() == 0) begin
      $display("== PASS ==");
    end else begin
      $display("== FAIL ==");
    end
    $finish;
  end

endmodule
